// File: rtl/tllt_pkg.sv
// ============================================================================
// tllt_pkg: shared types and constants for the link latency tracker
// Widths, table sizes, item kinds, sequencer states, item and result records.
// ============================================================================
package tllt_pkg;

    localparam int LINK_ENTRIES = 1024;
    localparam int VLAN_ENTRIES = 1024;
    localparam int LINK_AW      = $clog2(LINK_ENTRIES);
    localparam int VLAN_AW      = $clog2(VLAN_ENTRIES);
    localparam logic [4:0] EWMA_SHIFT_RESET = 5'd3;

    localparam logic KIND_HOP   = 1'b0;
    localparam logic KIND_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_LDONE,
        ST_VSCAN,
        ST_VDONE,
        ST_TSCAN,
        ST_TDONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] link_switch_one;
        logic [31:0] link_switch_two;
        logic [31:0] measured_latency;
        logic [31:0] average_latency;
        logic [31:0] total_packets;
        logic [31:0] above_packets;
        logic        above_now;
        logic        link_table_full;
        logic        vlan_table_full;
    } result_t;

    typedef struct packed {
        logic        kind;
        logic        hop_first;
        logic [31:0] hop_switch;
        logic [31:0] hop_ingress;
        logic [31:0] hop_egress;
        logic [11:0] hop_vlan;
        logic [31:0] key_switch_one;
        logic [31:0] key_switch_two;
        logic [11:0] key_vlan;
        logic [31:0] threshold_value;
    } item_t;

endpackage

// File: rtl/tllt_if.sv
// ============================================================================
// tllt_if: valid/ready channel carrying a payload of parametric type
// Source drives valid and payload, sink drives ready.
// ============================================================================
interface tllt_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tllt_ram.sv
// ============================================================================
// tllt_ram: single-port synchronous RAM
// One read or write per cycle, registered read data.
// ============================================================================
module tllt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/telemetry_link_latency_tracker.sv
// ============================================================================
// telemetry_link_latency_tracker: per-link EWMA latency and VLAN counters
// Top level: sequencer scanning fully associative tables held in RAMs.
// ============================================================================
// Usage:
//   in  (sink)  : hop record (kind 0) or threshold write (kind 1).
//   out (source): link report or threshold acknowledgment, one per item
//                 except first-of-packet hop records, which give none.
//   cfg (sink)  : ewma_shift write, taken only while idle.
// Each table is fully associative and searched one entry a cycle through
// its RAM port (each table holds 1024 entries): a hop record scans the link
// table, the link+VLAN table and, on a counter hit, the threshold table; a
// threshold write scans the threshold table. A scan stops early at a hit.
// The search loop over the RAM read port sets the rate. One item is in work
// at a time.
// Entries are never freed, so each table fills from slot 0 upward and a
// fill count marks its valid entries. Reset clears the fill counts and the
// previous-hop registers, and sets ewma_shift to 3. A stalled receiver holds
// the result register; the next item is taken only once the result has been
// transferred.
// ============================================================================
module telemetry_link_latency_tracker
    import tllt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tllt_if.sink   in,
    tllt_if.source out,
    tllt_if.sink   cfg
);
    state_t state_reg, state_next;
    item_t  item_reg;
    logic [4:0]  shift_reg;
    logic [31:0] prev_sw_reg, prev_ing_reg, other_reg, lat_reg;
    logic [LINK_AW:0] lidx_reg, lidx_next;
    logic [VLAN_AW:0] vidx_reg, vidx_next;
    logic [LINK_AW-1:0] lfree_reg;
    logic [VLAN_AW-1:0] vfree_reg;
    logic lfree_ok_reg, vfree_ok_reg;
    logic [VLAN_AW-1:0] vhit_reg;
    logic [31:0] vtot_reg, vabove_reg;
    logic [LINK_AW:0] lcnt_reg;
    logic [VLAN_AW:0] vcnt_reg, tcnt_reg;
    result_t res_reg;
    result_t res_load;
    logic out_valid_reg;

    // RAM ports
    logic l_we, v_we, t_we;
    logic [LINK_AW-1:0] l_addr;
    logic [VLAN_AW-1:0] v_addr, t_addr;
    logic [95:0]  l_wd, l_rd;
    logic [139:0] v_wd, v_rd;
    logic [107:0] t_wd, t_rd;

    tllt_ram #(.DEPTH(LINK_ENTRIES), .WIDTH(96)) u_link (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
    tllt_ram #(.DEPTH(VLAN_ENTRIES), .WIDTH(140)) u_vlan (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
    tllt_ram #(.DEPTH(VLAN_ENTRIES), .WIDTH(108)) u_limit (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));

    // scan bookkeeping: index of the entry whose data arrives this cycle
    logic [LINK_AW-1:0] lcur;
    logic [VLAN_AW-1:0] vcur;
    logic lcur_val, vcur_val, tcur_val;
    logic lmatch, vmatch, tmatch;
    logic [31:0] hop_sw, t_one, t_two;
    logic [11:0] t_vlan;
    logic [31:0] old_avg, new_avg;

    assign lcur     = lidx_reg[LINK_AW-1:0] - 1'b1;
    assign vcur     = vidx_reg[VLAN_AW-1:0] - 1'b1;
    assign lcur_val = {1'b0, lcur} < lcnt_reg;
    assign vcur_val = {1'b0, vcur} < vcnt_reg;
    assign tcur_val = {1'b0, vcur} < tcnt_reg;
    assign hop_sw   = item_reg.hop_switch;
    assign t_one    = (item_reg.kind == KIND_LIMIT) ? item_reg.key_switch_one : hop_sw;
    assign t_two    = (item_reg.kind == KIND_LIMIT) ? item_reg.key_switch_two : other_reg;
    assign t_vlan   = (item_reg.kind == KIND_LIMIT) ? item_reg.key_vlan : item_reg.hop_vlan;
    assign lmatch   = lcur_val && l_rd[95:64] == hop_sw && l_rd[63:32] == other_reg;
    assign vmatch   = vcur_val && v_rd[139:108] == hop_sw && v_rd[107:76] == other_reg
                      && v_rd[75:64] == item_reg.hop_vlan;
    assign tmatch   = tcur_val && t_rd[107:76] == t_one && t_rd[75:44] == t_two
                      && t_rd[43:32] == t_vlan;
    assign old_avg  = l_rd[31:0];
    assign new_avg  = (lat_reg >> shift_reg) + old_avg - (old_avg >> shift_reg);

    assign in.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out.valid = out_valid_reg;
    assign out.data  = res_reg;

    // initial result for an accepted item
    always_comb
    begin
        res_load                 = '0;
        res_load.result_kind     = in.data.kind;
        res_load.link_switch_one = (in.data.kind == KIND_LIMIT)
                                   ? in.data.key_switch_one : in.data.hop_switch;
        res_load.link_switch_two = (in.data.kind == KIND_LIMIT)
                                   ? in.data.key_switch_two : prev_sw_reg;
        res_load.measured_latency = (in.data.kind == KIND_LIMIT)
                                    ? 32'd0 : prev_ing_reg - in.data.hop_egress;
    end

    // next state and RAM control
    always_comb
    begin
        state_next = state_reg;
        lidx_next  = lidx_reg;
        vidx_next  = vidx_reg;
        l_we = 1'b0; v_we = 1'b0; t_we = 1'b0;
        l_addr = lidx_reg[LINK_AW-1:0];
        v_addr = vidx_reg[VLAN_AW-1:0];
        t_addr = vidx_reg[VLAN_AW-1:0];
        l_wd = {hop_sw, other_reg, lat_reg};
        v_wd = {hop_sw, other_reg, item_reg.hop_vlan, 32'd1, 32'd0};
        t_wd = {t_one, t_two, t_vlan, item_reg.threshold_value};
        case (state_reg)
            ST_IDLE:
            begin
                lidx_next = '0;
                vidx_next = '0;
                if (in.valid && in.ready)
                begin
                    if (in.data.kind == KIND_LIMIT)
                    begin
                        state_next = ST_TSCAN;
                        vidx_next  = (VLAN_AW+1)'(1);
                    end
                    else if (!in.data.hop_first)
                    begin
                        state_next = ST_LSCAN;
                        lidx_next  = (LINK_AW+1)'(1);
                    end
                end
            end
            ST_LSCAN:
            begin
                if (lmatch)
                begin
                    l_addr = lcur;
                    l_wd   = {hop_sw, other_reg, new_avg};
                    l_we   = 1'b1;
                    state_next = ST_VSCAN;
                    vidx_next  = (VLAN_AW+1)'(1);
                    v_addr = '0;
                end
                else if (lidx_reg == (LINK_AW+1)'(LINK_ENTRIES))
                begin
                    state_next = ST_LDONE;
                end
                else
                begin
                    lidx_next = lidx_reg + 1'b1;
                end
            end
            ST_LDONE:
            begin
                l_addr = lfree_reg;
                l_we   = lfree_ok_reg;
                state_next = ST_VSCAN;
                vidx_next  = (VLAN_AW+1)'(1);
                v_addr = '0;
            end
            ST_VSCAN:
            begin
                if (vmatch)
                begin
                    state_next = ST_TSCAN;
                    vidx_next  = (VLAN_AW+1)'(1);
                    t_addr = '0;
                end
                else if (vidx_reg == (VLAN_AW+1)'(VLAN_ENTRIES))
                begin
                    state_next = ST_VDONE;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_VDONE:
            begin
                v_addr = vfree_reg;
                v_we   = vfree_ok_reg;
                state_next = ST_OUT;
            end
            ST_TSCAN:
            begin
                if (tmatch || vidx_reg == (VLAN_AW+1)'(VLAN_ENTRIES))
                begin
                    state_next = ST_TDONE;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_TDONE:
            begin
                state_next = ST_OUT;
                if (item_reg.kind == KIND_LIMIT)
                begin
                    // write only when a hit or a free slot was found
                    t_addr = vhit_reg;
                    t_we   = vfree_ok_reg;
                end
                else
                begin
                    v_addr = vhit_reg;
                    v_we   = 1'b1;
                    v_wd   = {hop_sw, other_reg, item_reg.hop_vlan, vtot_reg, vabove_reg};
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= EWMA_SHIFT_RESET;
            prev_sw_reg   <= '0;
            prev_ing_reg  <= '0;
            lcnt_reg      <= '0;
            vcnt_reg      <= '0;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            lidx_reg      <= '0;
            vidx_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lidx_reg  <= lidx_next;
            vidx_reg  <= vidx_next;
            if (cfg.valid && cfg.ready)
            begin
                shift_reg <= cfg.data;
            end
            if (in.valid && in.ready && in.data.kind == KIND_HOP)
            begin
                prev_sw_reg  <= in.data.hop_switch;
                prev_ing_reg <= in.data.hop_ingress;
            end
            // advance a fill count when a write lands on its first free slot
            if (l_we && {1'b0, l_addr} == lcnt_reg)
            begin
                lcnt_reg <= lcnt_reg + 1'b1;
            end
            if (v_we && {1'b0, v_addr} == vcnt_reg)
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
            if (t_we && {1'b0, t_addr} == tcnt_reg)
            begin
                tcnt_reg <= tcnt_reg + 1'b1;
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.valid && out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: capture item, track free slots, build result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in.valid && in.ready)
                begin
                    item_reg     <= in.data;
                    other_reg    <= prev_sw_reg;
                    lat_reg      <= prev_ing_reg - in.data.hop_egress;
                    lfree_ok_reg <= 1'b0;
                    vfree_ok_reg <= 1'b0;
                    res_reg      <= res_load;
                end
            end
            ST_LSCAN:
            begin
                if (lmatch)
                begin
                    res_reg.average_latency <= new_avg;
                end
                else if (!lcur_val && !lfree_ok_reg)
                begin
                    lfree_reg    <= lcur;
                    lfree_ok_reg <= 1'b1;
                end
            end
            ST_LDONE:
            begin
                res_reg.average_latency <= lfree_ok_reg ? lat_reg : 32'd0;
                res_reg.link_table_full <= !lfree_ok_reg;
            end
            ST_VSCAN:
            begin
                if (vmatch)
                begin
                    vhit_reg   <= vcur;
                    vtot_reg   <= v_rd[63:32] + 32'd1;
                    vabove_reg <= v_rd[31:0];
                end
                else if (!vcur_val && !vfree_ok_reg)
                begin
                    vfree_reg    <= vcur;
                    vfree_ok_reg <= 1'b1;
                end
            end
            ST_VDONE:
            begin
                res_reg.total_packets   <= vfree_ok_reg ? 32'd1 : 32'd0;
                res_reg.vlan_table_full <= !vfree_ok_reg;
            end
            ST_TSCAN:
            begin
                if (item_reg.kind == KIND_LIMIT)
                begin
                    if (tmatch)
                    begin
                        vhit_reg     <= vcur;
                        vfree_ok_reg <= 1'b1;
                    end
                    else if (!tcur_val && !vfree_ok_reg)
                    begin
                        vhit_reg     <= vcur;
                        vfree_ok_reg <= 1'b1;
                    end
                    else if (vidx_reg == (VLAN_AW+1)'(VLAN_ENTRIES) && !vfree_ok_reg)
                    begin
                        res_reg.vlan_table_full <= 1'b1;
                    end
                end
                else if (tmatch && lat_reg > t_rd[31:0])
                begin
                    vabove_reg <= vabove_reg + 32'd1;
                    res_reg.above_now <= 1'b1;
                end
            end
            ST_TDONE:
            begin
                if (item_reg.kind == KIND_HOP)
                begin
                    res_reg.total_packets <= vtot_reg;
                    res_reg.above_packets <= vabove_reg;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// File: rtl/tllt_checker.sv
// ============================================================================
// tllt_checker: port-level checks for the link latency tracker
// Watches handshakes of the top level and is bound to it.
// ============================================================================
module tllt_checker
    import tllt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    // no input taken while a result waits
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");

    // acknowledgments carry zero measured latency and a clear above_now flag
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_LIMIT |->
        out_data.measured_latency == 32'd0 && out_data.above_now == 1'b0)
        else $error("ack with nonzero fields");
endmodule

bind telemetry_link_latency_tracker tllt_checker u_tllt_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data));
